### hdl/utf8d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int CpW  = 21;  // code point width
  localparam int LenW = 3;   // sequence length width
  localparam int CntW = 3;   // results-per-word count width

  localparam int DefaultQueueDepth = 4;

  localparam logic [LenW-1:0] LenErr  = 3'd0;
  localparam logic [LenW-1:0] LenOne  = 3'd1;
  localparam logic [LenW-1:0] LenTwo  = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour = 3'd4;

  localparam logic [CpW-1:0] MinTwo       = 21'h000080;
  localparam logic [CpW-1:0] MinThree     = 21'h000800;
  localparam logic [CpW-1:0] MinFour      = 21'h010000;
  localparam logic [CpW-1:0] MaxScalar    = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrogateLo  = 21'h00D800;
  localparam logic [CpW-1:0] SurrogateHi  = 21'h00DFFF;

  // What one input word expands to: err_count error results, then an
  // optional tail result (a code point, or one more error).
  typedef struct packed {
    logic [CntW-1:0] err_count;
    logic            tail_valid;
    logic [CpW-1:0]  tail_cp;
    logic [LenW-1:0] tail_len;
  } desc_t;

endpackage
`default_nettype wire

### hdl/utf8d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts bytes, tracks the open sequence and turns each byte that yields
// results into a result descriptor for the queue.
// ----------------------------------------------------------------------------
module utf8d_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [7:0]             text_byte,
  input  wire logic                   end_of_text,
  input  wire logic                   in_valid,
  input  wire logic                   q_not_full,
  output logic                        in_ready,
  output logic                        push,
  output utf8d_pkg::desc_t            push_desc
);
  import utf8d_pkg::*;

  logic [CpW-1:0]  partial_value, partial_value_next;
  logic [LenW-1:0] expected_length, expected_length_next;
  logic [CntW-1:0] bytes_held, bytes_held_next;

  logic            is_cont;
  logic [CpW-1:0]  pv_shift;
  logic [CntW-1:0] held_inc;
  logic            value_ok;
  logic            lead_ascii, lead_open;
  logic [CpW-1:0]  lead_v;
  logic [LenW-1:0] lead_len;
  logic            accept;
  desc_t           d;

  assign in_ready = q_not_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = (text_byte[7:6] == 2'b10);
  assign pv_shift = {partial_value[CpW-7:0], text_byte[5:0]};
  assign held_inc = bytes_held + CntW'(1);

  always_comb begin
    value_ok = 1'b1;
    if (expected_length == LenTwo && pv_shift < MinTwo) value_ok = 1'b0;
    if (expected_length == LenThree && pv_shift < MinThree) value_ok = 1'b0;
    if (expected_length == LenFour && (pv_shift < MinFour || pv_shift > MaxScalar))
      value_ok = 1'b0;
    if (pv_shift >= SurrogateLo && pv_shift <= SurrogateHi) value_ok = 1'b0;
  end

  always_comb begin
    lead_ascii = 1'b0;
    lead_open  = 1'b0;
    lead_v     = '0;
    lead_len   = LenErr;
    priority if (text_byte[7] == 1'b0) begin
      lead_ascii = 1'b1;
    end else if (text_byte[7:5] == 3'b110) begin
      lead_open = 1'b1;
      lead_v    = CpW'(text_byte[4:0]);
      lead_len  = LenTwo;
    end else if (text_byte[7:4] == 4'b1110) begin
      lead_open = 1'b1;
      lead_v    = CpW'(text_byte[3:0]);
      lead_len  = LenThree;
    end else if (text_byte[7:3] == 5'b11110) begin
      lead_open = 1'b1;
      lead_v    = CpW'(text_byte[2:0]);
      lead_len  = LenFour;
    end else begin
      lead_open = 1'b0;
    end
  end

  always_comb begin
    logic do_lead;
    do_lead              = 1'b0;
    partial_value_next   = partial_value;
    expected_length_next = expected_length;
    bytes_held_next      = bytes_held;
    d.err_count          = '0;
    d.tail_valid         = 1'b0;
    d.tail_cp            = '0;
    d.tail_len           = LenErr;

    if (expected_length != LenErr) begin
      if (is_cont) begin
        partial_value_next = pv_shift;
        bytes_held_next    = held_inc;
        if (held_inc >= expected_length) begin
          if (value_ok) begin
            d.tail_valid = 1'b1;
            d.tail_cp    = pv_shift;
            d.tail_len   = expected_length;
          end else begin
            d.err_count = held_inc;
          end
          partial_value_next   = '0;
          expected_length_next = LenErr;
          bytes_held_next      = '0;
        end else if (end_of_text) begin
          d.err_count          = held_inc;
          partial_value_next   = '0;
          expected_length_next = LenErr;
          bytes_held_next      = '0;
        end
      end else begin
        // broken sequence: flush held bytes, then retry this byte as a lead
        d.err_count          = bytes_held;
        partial_value_next   = '0;
        expected_length_next = LenErr;
        bytes_held_next      = '0;
        do_lead              = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead) begin
      if (lead_ascii) begin
        d.tail_valid = 1'b1;
        d.tail_cp    = CpW'(text_byte);
        d.tail_len   = LenOne;
      end else if (lead_open && !end_of_text) begin
        partial_value_next   = lead_v;
        expected_length_next = lead_len;
        bytes_held_next      = CntW'(1);
      end else begin
        d.tail_valid = 1'b1;
      end
    end
  end

  assign push      = accept && (d.err_count != '0 || d.tail_valid);
  assign push_desc = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      expected_length <= LenErr;
      bytes_held      <= '0;
    end else if (accept) begin
      partial_value   <= partial_value_next;
      expected_length <= expected_length_next;
      bytes_held      <= bytes_held_next;
    end
  end

endmodule
`default_nettype wire

### hdl/utf8d_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_queue
// Small register FIFO of result descriptors between front and back.
// ----------------------------------------------------------------------------
module utf8d_queue #(
  parameter int Depth = utf8d_pkg::DefaultQueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  utf8d_pkg::desc_t      push_desc,
  input  wire logic             pop,
  output utf8d_pkg::desc_t      head,
  output logic                  not_empty,
  output logic                  not_full
);
  import utf8d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntQ = $clog2(Depth + 1);

  desc_t           entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntQ-1:0] count;

  assign not_empty = (count != '0);
  assign not_full  = (count != CntQ'(Depth));
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntQ'(1);
      end else if (pop && !push) begin
        count <= count - CntQ'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hdl/utf8d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_back
// Expands the head descriptor into one result per cycle, while the output
// is not stalled, into the output register; pops the descriptor with its last result.
// ----------------------------------------------------------------------------
module utf8d_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  utf8d_pkg::desc_t                     head,
  input  wire logic                            head_valid,
  output logic                                 pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [utf8d_pkg::CpW-1:0]            code_point,
  output logic [utf8d_pkg::LenW-1:0]           seq_length,
  output logic                                 last_of_run
);
  import utf8d_pkg::*;

  logic [CntW-1:0] sent, sent_next;
  logic [CntW-1:0] total;
  logic            load;
  logic            is_err;
  logic            is_last;

  assign total   = head.err_count + CntW'(head.tail_valid);
  assign load    = head_valid && (!out_valid || out_ready);
  assign is_err  = (sent < head.err_count);
  assign is_last = ((sent + CntW'(1)) == total);
  assign pop     = load && is_last;

  always_comb begin
    sent_next = sent;
    if (load) begin
      sent_next = is_last ? '0 : sent + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= '0;
    end else begin
      sent <= sent_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point  <= is_err ? '0 : head.tail_cp;
      seq_length  <= is_err ? LenErr : head.tail_len;
      last_of_run <= is_last;
    end
  end

endmodule
`default_nettype wire

### hdl/utf8_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with error resync.
// ----------------------------------------------------------------------------
// Input channel: text_byte/end_of_text with in_valid/in_ready, one byte per
// word. Output channel: code_point/seq_length/last_of_run with
// out_valid/out_ready. A good sequence yields one word with its length; a
// rejected one yields one error word (code_point 0, seq_length 0) per byte.
// last_of_run marks the final word caused by an input byte.
// The first result of a byte is written into the descriptor queue when the
// byte is accepted and loaded into the output register once its descriptor
// heads the queue and the output is not stalled. Throughput: one byte per
// cycle while each byte gives at most one result; a byte giving k results
// holds the output side until the one-word-per-cycle expander has sent
// them. The descriptor queue (QueueDepth entries) absorbs such runs;
// in_ready drops only when it is full. When the receiver stalls, the output
// word holds and the queue fills, then in_ready goes low. Reset closes any
// open sequence and empties the queue and the output register.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
  parameter int QueueDepth = utf8d_pkg::DefaultQueueDepth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [7:0]                    text_byte,
  input  wire logic                          end_of_text,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  output logic [utf8d_pkg::CpW-1:0]          code_point,
  output logic [utf8d_pkg::LenW-1:0]         seq_length,
  output logic                               last_of_run,
  output logic                               out_valid,
  input  wire logic                          out_ready
);
  import utf8d_pkg::*;

  logic  push, pop, q_not_empty, q_not_full;
  desc_t push_desc, head;

  utf8d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .in_valid    (in_valid),
    .q_not_full  (q_not_full),
    .in_ready    (in_ready),
    .push        (push),
    .push_desc   (push_desc)
  );

  utf8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  utf8d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (q_not_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .seq_length  (seq_length),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

### hdl/utf8d_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder's output channel.
// ----------------------------------------------------------------------------
module utf8d_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [utf8d_pkg::CpW-1:0]     code_point,
  input wire logic [utf8d_pkg::LenW-1:0]    seq_length,
  input wire logic                          last_of_run
);
  import utf8d_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point)
      && $stable(seq_length) && $stable(last_of_run))
    else $error("output word changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && seq_length == LenErr |-> code_point == '0)
    else $error("error word with nonzero code point");

  // a decoded code point is never followed by more words of the same byte
  a_good_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && seq_length != LenErr |-> last_of_run)
    else $error("decoded word not last of run");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seq_length <= LenFour && code_point <= MaxScalar
      && !(code_point >= SurrogateLo && code_point <= SurrogateHi))
    else $error("output out of range");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .code_point  (code_point),
  .seq_length  (seq_length),
  .last_of_run (last_of_run)
);
`default_nettype wire
